@@ hdl/rbap_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rbap_pkg;

    // fixed width of the length field on the result port
    localparam int LEN_W = 63;
    localparam int COUNT_WIDTH_DEF = 63;

    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] MARK_ARRAY  = 8'h2A;
    localparam logic [7:0] MARK_STRING = 8'h24;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NOISE_CR,
        MODE_HEADER,
        MODE_HEADER_LF,
        MODE_PAYLOAD,
        MODE_PAYLOAD_CR,
        MODE_PAYLOAD_LF
    } t_mode;

    typedef enum logic [2:0] {
        KIND_ARRAY  = 3'd0,
        KIND_STRING = 3'd1,
        KIND_BYTE   = 3'd2,
        KIND_DONE   = 3'd3,
        KIND_ERROR  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ERR_ARRAY  = 2'd0,
        ERR_STRING = 2'd1,
        ERR_CRLF   = 2'd2
    } t_err;

    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic             last;
        t_err             err;
    } t_result;

endpackage

`default_nettype wire

@@ hdl/rbap_digit_acc.sv @@
`timescale 1ns / 1ps
`default_nettype none

// acc * 10 + digit with overflow against 2^CW - 1
module rbap_digit_acc #(
    parameter int CW = rbap_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic [CW-1:0] i_acc,
    input  wire logic [3:0]    i_digit,
    output logic      [CW-1:0] o_acc,
    output logic               o_overflow
);

    logic [CW+3:0] wide;

    always_comb begin
        wide = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0} + {{CW{1'b0}}, i_digit};
        o_acc = wide[CW-1:0];
        o_overflow = |wide[CW+3:CW];
    end

endmodule

`default_nettype wire

@@ hdl/rbap_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// parser state and per-byte next-state / result logic
module rbap_core #(
    parameter int CW = rbap_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_byte,
    output rbap_pkg::t_result    o_res
);

    rbap_pkg::t_mode r_mode, n_mode;
    logic            r_is_array, n_is_array;
    logic            r_pos0, n_pos0;
    logic            r_bad, n_bad;
    logic            r_seen, n_seen;
    logic [CW-1:0]   r_acc, n_acc;
    logic [CW-1:0]   r_elems, n_elems;
    logic [CW-1:0]   r_payload, n_payload;

    logic [CW-1:0]   acc_next;
    logic            acc_ovf;
    logic            is_digit;
    logic            last;
    logic [7:0]      mark;
    logic            hdr_fail;

    rbap_digit_acc #(.CW(CW)) u_digit (
        .i_acc      (r_acc),
        .i_digit    (i_byte[3:0]),
        .o_acc      (acc_next),
        .o_overflow (acc_ovf)
    );

    assign is_digit = (i_byte >= rbap_pkg::CHAR_ZERO) && (i_byte <= rbap_pkg::CHAR_NINE);
    assign last = (r_payload <= CW'(1));
    assign mark = r_is_array ? rbap_pkg::MARK_ARRAY : rbap_pkg::MARK_STRING;
    // header closes badly: no LF after CR, bad field, no digits or a zero count
    assign hdr_fail = (i_byte != rbap_pkg::BYTE_LF) || r_bad || !r_seen || (r_acc == '0);

    // next state
    always_comb begin
        n_mode     = r_mode;
        n_is_array = r_is_array;
        n_pos0     = r_pos0;
        n_bad      = r_bad;
        n_seen     = r_seen;
        n_acc      = r_acc;
        n_elems    = r_elems;
        n_payload  = r_payload;

        unique case (r_mode)
            rbap_pkg::MODE_IDLE: begin
                if (i_byte == rbap_pkg::BYTE_CR) begin
                    n_mode = rbap_pkg::MODE_NOISE_CR;
                end else begin
                    // opening byte of an array header: type mark only
                    n_mode     = rbap_pkg::MODE_HEADER;
                    n_is_array = 1'b1;
                    n_pos0     = 1'b0;
                    n_bad      = (i_byte != rbap_pkg::MARK_ARRAY);
                    n_seen     = 1'b0;
                    n_acc      = '0;
                end
            end
            rbap_pkg::MODE_NOISE_CR: begin
                n_mode = rbap_pkg::MODE_IDLE;
            end
            rbap_pkg::MODE_HEADER: begin
                if (i_byte == rbap_pkg::BYTE_CR) begin
                    n_mode = rbap_pkg::MODE_HEADER_LF;
                end else if (r_pos0) begin
                    n_pos0 = 1'b0;
                    if (i_byte != mark) begin
                        n_bad = 1'b1;
                    end
                end else if (is_digit) begin
                    n_seen = 1'b1;
                    if (!r_bad) begin
                        if (acc_ovf) begin
                            n_bad = 1'b1;
                        end else begin
                            n_acc = acc_next;
                        end
                    end
                end else begin
                    n_bad = 1'b1;
                end
            end
            rbap_pkg::MODE_HEADER_LF: begin
                if (hdr_fail) begin
                    n_mode = rbap_pkg::MODE_IDLE;
                end else if (r_is_array) begin
                    n_elems    = r_acc;
                    n_mode     = rbap_pkg::MODE_HEADER;
                    n_is_array = 1'b0;
                    n_pos0     = 1'b1;
                    n_bad      = 1'b0;
                    n_seen     = 1'b0;
                    n_acc      = '0;
                end else begin
                    n_payload = r_acc;
                    n_mode    = rbap_pkg::MODE_PAYLOAD;
                end
            end
            rbap_pkg::MODE_PAYLOAD: begin
                if (last) begin
                    n_payload = '0;
                    n_mode    = rbap_pkg::MODE_PAYLOAD_CR;
                end else begin
                    n_payload = r_payload - CW'(1);
                end
            end
            rbap_pkg::MODE_PAYLOAD_CR: begin
                if (i_byte == rbap_pkg::BYTE_CR) begin
                    n_mode = rbap_pkg::MODE_PAYLOAD_LF;
                end else begin
                    n_mode = rbap_pkg::MODE_IDLE;
                end
            end
            rbap_pkg::MODE_PAYLOAD_LF: begin
                if (i_byte != rbap_pkg::BYTE_LF) begin
                    n_mode = rbap_pkg::MODE_IDLE;
                end else if (r_elems <= CW'(1)) begin
                    n_elems = '0;
                    n_mode  = rbap_pkg::MODE_IDLE;
                end else begin
                    n_elems    = r_elems - CW'(1);
                    n_mode     = rbap_pkg::MODE_HEADER;
                    n_is_array = 1'b0;
                    n_pos0     = 1'b1;
                    n_bad      = 1'b0;
                    n_seen     = 1'b0;
                    n_acc      = '0;
                end
            end
            default: begin
                n_mode = rbap_pkg::MODE_IDLE;
            end
        endcase
    end

    // result for the byte being decoded
    always_comb begin
        o_res      = '0;
        o_res.kind = rbap_pkg::KIND_ARRAY;
        o_res.err  = rbap_pkg::ERR_ARRAY;

        unique case (r_mode)
            rbap_pkg::MODE_NOISE_CR: begin
                if (i_byte != rbap_pkg::BYTE_LF) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = rbap_pkg::KIND_ERROR;
                end
            end
            rbap_pkg::MODE_HEADER_LF: begin
                o_res.valid = 1'b1;
                if (hdr_fail) begin
                    o_res.kind = rbap_pkg::KIND_ERROR;
                    o_res.err  = r_is_array ? rbap_pkg::ERR_ARRAY : rbap_pkg::ERR_STRING;
                end else if (r_is_array) begin
                    o_res.kind = rbap_pkg::KIND_ARRAY;
                    o_res.len  = rbap_pkg::LEN_W'(r_acc);
                end else begin
                    o_res.kind = rbap_pkg::KIND_STRING;
                    o_res.len  = rbap_pkg::LEN_W'(r_acc);
                end
            end
            rbap_pkg::MODE_PAYLOAD: begin
                o_res.valid = 1'b1;
                o_res.kind  = rbap_pkg::KIND_BYTE;
                o_res.data  = i_byte;
                o_res.last  = last;
            end
            rbap_pkg::MODE_PAYLOAD_CR: begin
                if (i_byte != rbap_pkg::BYTE_CR) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = rbap_pkg::KIND_ERROR;
                    o_res.err   = rbap_pkg::ERR_CRLF;
                end
            end
            rbap_pkg::MODE_PAYLOAD_LF: begin
                if (i_byte != rbap_pkg::BYTE_LF) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = rbap_pkg::KIND_ERROR;
                    o_res.err   = rbap_pkg::ERR_CRLF;
                end else if (r_elems <= CW'(1)) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = rbap_pkg::KIND_DONE;
                end
            end
            default: begin
                o_res.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= rbap_pkg::MODE_IDLE;
            r_is_array <= 1'b1;
            r_pos0     <= 1'b1;
            r_bad      <= 1'b0;
            r_seen     <= 1'b0;
            r_acc      <= '0;
            r_elems    <= '0;
            r_payload  <= '0;
        end else if (i_step) begin
            r_mode     <= n_mode;
            r_is_array <= n_is_array;
            r_pos0     <= n_pos0;
            r_bad      <= n_bad;
            r_seen     <= n_seen;
            r_acc      <= n_acc;
            r_elems    <= n_elems;
            r_payload  <= n_payload;
        end
    end

endmodule

`default_nettype wire

@@ hdl/resp_bulk_array_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

// streaming decoder for messages made of an array of bulk strings
// input channel: one raw byte per transfer (i_valid / o_stall / i_in_byte)
// output channel: zero or one event per input byte (o_valid / i_stall), each
//   event carrying kind, payload byte, length, last-of-string flag, error code
// events are array start, string start, payload byte, message done, error;
//   a consumer drops a message that ends in an error event
// throughput: one byte per cycle, sustained, as long as the receiver keeps up
// a taken byte lands in the input register and is decoded from there; its event
//   is written into the result register, which drives the output channel
// the count accumulator is one add of x8 + x2 + digit per header byte, which
//   sets the critical path between the input register and the count register
// reset (synchronous, active low) empties both registers and puts the parser
//   between messages, ready for a new header
// when the receiver stalls, the result register holds its event unchanged;
//   one more byte may sit in the input register, after which o_stall is raised
// bytes that give no event move through without using the output register
module resp_bulk_array_parser #(
    parameter int COUNT_WIDTH = rbap_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // byte input channel
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic [7:0]                 i_in_byte,
    // event output channel
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [2:0]                      o_kind,
    output logic [7:0]                      o_data_byte,
    output logic [rbap_pkg::LEN_W-1:0]      o_length_value,
    output logic                            o_last_of_string,
    output logic [1:0]                      o_error_code
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_out_valid;
    rbap_pkg::t_result r_out;
    rbap_pkg::t_result res;

    logic advance;   // result register may take a new value
    logic step;      // buffered byte is decoded this cycle
    logic in_ready;

    assign advance  = !r_out_valid || !i_stall;
    assign step     = r_in_valid && advance;
    assign in_ready = !r_in_valid || advance;
    assign o_stall  = !in_ready;

    rbap_core #(.CW(COUNT_WIDTH)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_out.kind;
    assign o_data_byte      = r_out.data;
    assign o_length_value   = r_out.len;
    assign o_last_of_string = r_out.last;
    assign o_error_code     = r_out.err;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

// bench for the array-of-bulk-strings decoder
// a byte stream is fed one byte per transfer; a local decoder model tracks the
// parse state and queues the event that each accepted byte should produce;
// every event transfer on the output side is checked against the oldest one
module tb_top;

    localparam int          ITEM_TARGET = 800;
    localparam int          HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_LIMIT = 5000;
    localparam int          MAX_REPORTS = 10;
    // largest count a header may carry with a 63-bit count field
    localparam logic [63:0] COUNT_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        rbap_pkg::t_kind            kind;
        logic [7:0]                 data;
        logic [rbap_pkg::LEN_W-1:0] len;
        logic                       last;
        rbap_pkg::t_err             err;
    } t_parse_event;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [7:0]                 i_in_byte;
    logic                       o_valid;
    logic                       i_stall;
    logic [2:0]                 o_kind;
    logic [7:0]                 o_data_byte;
    logic [rbap_pkg::LEN_W-1:0] o_length_value;
    logic                       o_last_of_string;
    logic [1:0]                 o_error_code;

    resp_bulk_array_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_in_byte        (i_in_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_length_value   (o_length_value),
        .o_last_of_string (o_last_of_string),
        .o_error_code     (o_error_code)
    );

    // decoder model state
    rbap_pkg::t_mode dec_mode   = rbap_pkg::MODE_IDLE;
    bit              hdr_array  = 1'b1;
    bit              hdr_first  = 1'b1;
    bit              hdr_bad    = 1'b0;
    bit              hdr_digit  = 1'b0;
    logic [63:0]     hdr_count  = '0;
    logic [63:0]     elems_left = '0;
    logic [63:0]     bytes_left = '0;

    // events still owed by the block, oldest first
    t_parse_event expected_events[$];
    // bytes of the frame being built for the sender
    logic [7:0]   frame[$];

    // idling knobs, hold request and run counters
    bit feed_idle   = 1'b1;
    bit drain_idle  = 1'b1;
    bit hold_go     = 1'b0;
    bit hold_active = 1'b0;
    int bytes_sent     = 0;
    int events_seen    = 0;
    int mismatch_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // decoder model
    // ---------------------------------------------------------------

    // clear the header field tracker for a new '*' or '$' header
    function automatic void start_field(bit is_array);
        hdr_array = is_array;
        hdr_first = 1'b1;
        hdr_bad   = 1'b0;
        hdr_digit = 1'b0;
        hdr_count = '0;
    endfunction

    // one byte inside a header; CR ends the field, anything else (LF too) is
    // part of it
    function automatic void take_header_char(logic [7:0] b);
        logic [63:0] digit;
        if (b == rbap_pkg::BYTE_CR) begin
            dec_mode = rbap_pkg::MODE_HEADER_LF;
            return;
        end
        if (hdr_first) begin
            hdr_first = 1'b0;
            if (b != (hdr_array ? rbap_pkg::MARK_ARRAY : rbap_pkg::MARK_STRING))
                hdr_bad = 1'b1;
        end else if (b >= rbap_pkg::CHAR_ZERO && b <= rbap_pkg::CHAR_NINE) begin
            digit     = 64'(b - rbap_pkg::CHAR_ZERO);
            hdr_digit = 1'b1;
            // stop accumulating once the count would pass the limit
            if (!hdr_bad) begin
                if (hdr_count > (COUNT_MAX - digit) / 64'd10)
                    hdr_bad = 1'b1;
                else
                    hdr_count = hdr_count * 64'd10 + digit;
            end
        end else begin
            hdr_bad = 1'b1;
        end
    endfunction

    // advance the model by one stream byte; got is set when an event results
    function automatic void decode_byte(input logic [7:0] b, output bit got,
                                        output t_parse_event ev);
        got = 1'b0;
        ev  = '{kind: rbap_pkg::KIND_ARRAY, data: 8'h00, len: '0, last: 1'b0,
                err: rbap_pkg::ERR_ARRAY};
        case (dec_mode)
            rbap_pkg::MODE_IDLE: begin
                if (b == rbap_pkg::BYTE_CR) begin
                    dec_mode = rbap_pkg::MODE_NOISE_CR;
                end else begin
                    start_field(1'b1);
                    dec_mode = rbap_pkg::MODE_HEADER;
                    take_header_char(b);
                end
            end
            rbap_pkg::MODE_NOISE_CR: begin
                // a CR between messages must pair with LF
                dec_mode = rbap_pkg::MODE_IDLE;
                if (b != rbap_pkg::BYTE_LF) begin
                    got     = 1'b1;
                    ev.kind = rbap_pkg::KIND_ERROR;
                    ev.err  = rbap_pkg::ERR_ARRAY;
                end
            end
            rbap_pkg::MODE_HEADER: begin
                take_header_char(b);
            end
            rbap_pkg::MODE_HEADER_LF: begin
                got = 1'b1;
                if (b != rbap_pkg::BYTE_LF || hdr_bad || !hdr_digit || hdr_count == 64'd0) begin
                    dec_mode = rbap_pkg::MODE_IDLE;
                    ev.kind  = rbap_pkg::KIND_ERROR;
                    ev.err   = hdr_array ? rbap_pkg::ERR_ARRAY : rbap_pkg::ERR_STRING;
                end else if (hdr_array) begin
                    elems_left = hdr_count;
                    ev.kind    = rbap_pkg::KIND_ARRAY;
                    ev.len     = hdr_count[rbap_pkg::LEN_W-1:0];
                    start_field(1'b0);
                    dec_mode = rbap_pkg::MODE_HEADER;
                end else begin
                    bytes_left = hdr_count;
                    ev.kind    = rbap_pkg::KIND_STRING;
                    ev.len     = hdr_count[rbap_pkg::LEN_W-1:0];
                    dec_mode   = rbap_pkg::MODE_PAYLOAD;
                end
            end
            rbap_pkg::MODE_PAYLOAD: begin
                got     = 1'b1;
                ev.kind = rbap_pkg::KIND_BYTE;
                ev.data = b;
                ev.last = (bytes_left <= 64'd1);
                if (ev.last) begin
                    bytes_left = '0;
                    dec_mode   = rbap_pkg::MODE_PAYLOAD_CR;
                end else begin
                    bytes_left = bytes_left - 64'd1;
                end
            end
            rbap_pkg::MODE_PAYLOAD_CR: begin
                if (b == rbap_pkg::BYTE_CR) begin
                    dec_mode = rbap_pkg::MODE_PAYLOAD_LF;
                end else begin
                    dec_mode = rbap_pkg::MODE_IDLE;
                    got      = 1'b1;
                    ev.kind  = rbap_pkg::KIND_ERROR;
                    ev.err   = rbap_pkg::ERR_CRLF;
                end
            end
            rbap_pkg::MODE_PAYLOAD_LF: begin
                if (b != rbap_pkg::BYTE_LF) begin
                    dec_mode = rbap_pkg::MODE_IDLE;
                    got      = 1'b1;
                    ev.kind  = rbap_pkg::KIND_ERROR;
                    ev.err   = rbap_pkg::ERR_CRLF;
                end else if (elems_left <= 64'd1) begin
                    // last string closed, message complete
                    elems_left = '0;
                    dec_mode   = rbap_pkg::MODE_IDLE;
                    got        = 1'b1;
                    ev.kind    = rbap_pkg::KIND_DONE;
                end else begin
                    elems_left = elems_left - 64'd1;
                    start_field(1'b0);
                    dec_mode = rbap_pkg::MODE_HEADER;
                end
            end
            default: begin
                dec_mode = rbap_pkg::MODE_IDLE;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // byte sender
    // ---------------------------------------------------------------

    // called at a falling edge, returns at a falling edge; valid stays high
    // into a back-to-back byte since both writes sit in this one process
    task automatic send_byte(input logic [7:0] b);
        int           gap;
        bit           got;
        t_parse_event ev;
        gap = feed_idle ? int'($urandom_range(0, 11)) : 0;
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_in_byte = b;
        do @(posedge i_clk); while (o_stall);
        decode_byte(b, got, ev);
        if (got)
            expected_events.push_back(ev);
        bytes_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_frame();
        while (frame.size() > 0)
            send_byte(frame.pop_front());
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            frame.push_back(s[i]);
    endfunction

    function automatic void add_crlf();
        frame.push_back(rbap_pkg::BYTE_CR);
        frame.push_back(rbap_pkg::BYTE_LF);
    endfunction

    function automatic void add_header(logic [7:0] mark, logic [63:0] count);
        frame.push_back(mark);
        add_text($sformatf("%0d", count));
        add_crlf();
    endfunction

    // well-formed message with random payload content
    function automatic void add_message(int elems, int max_len);
        int len;
        add_header(rbap_pkg::MARK_ARRAY, 64'(elems));
        repeat (elems) begin
            len = int'($urandom_range(1, max_len));
            add_header(rbap_pkg::MARK_STRING, 64'(len));
            repeat (len) frame.push_back(8'($urandom_range(0, 255)));
            add_crlf();
        end
    endfunction

    // ---------------------------------------------------------------
    // event receiver and checker
    // ---------------------------------------------------------------

    task automatic check_event();
        t_parse_event want;
        if (expected_events.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("unexpected event: kind %0d data %02h len %0d last %0d err %0d",
                         o_kind, o_data_byte, o_length_value, o_last_of_string,
                         o_error_code);
            return;
        end
        want = expected_events.pop_front();
        if (o_kind !== want.kind || o_data_byte !== want.data ||
            o_length_value !== want.len || o_last_of_string !== want.last ||
            o_error_code !== want.err) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("event %0d mismatch: expected kind %0d data %02h len %0d last %0d err %0d",
                         events_seen, want.kind, want.data, want.len, want.last, want.err);
                $display("event %0d mismatch:      got kind %0d data %02h len %0d last %0d err %0d",
                         events_seen, o_kind, o_data_byte, o_length_value,
                         o_last_of_string, o_error_code);
            end
        end
        events_seen++;
    endtask

    // sample at the rising edge, drive stall at the falling edge
    initial begin : event_sink
        int wait_left;
        wait_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                check_event();
                wait_left = drain_idle ? int'($urandom_range(0, 11)) : 0;
            end
            @(negedge i_clk);
            i_stall = hold_active || (wait_left > 0);
            if (wait_left > 0)
                wait_left--;
        end
    end

    // long receiver hold, counted here so the sender keeps pushing meanwhile
    initial begin : long_hold
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
                wait (!hold_go);
            end
        end
    end

    // hard stop if the stream or the events get stuck
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d events still owed", cycles,
                 expected_events.size());
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // noise pairs, then a two-string message with extreme payload bytes and a
    // CR inside the payload
    task automatic test_well_formed();
        add_crlf();
        add_crlf();
        add_header(rbap_pkg::MARK_ARRAY, 64'd2);
        add_header(rbap_pkg::MARK_STRING, 64'd2);
        frame.push_back(8'h00);
        frame.push_back(8'hFF);
        add_crlf();
        add_header(rbap_pkg::MARK_STRING, 64'd1);
        frame.push_back(rbap_pkg::BYTE_CR);
        add_crlf();
        send_frame();
    endtask

    task automatic test_header_faults();
        // lone CR between messages
        frame.push_back(rbap_pkg::BYTE_CR);
        add_text("X");
        // header CR not followed by LF
        add_text("*1");
        frame.push_back(rbap_pkg::BYTE_CR);
        add_text("X");
        // LF inside the count field
        add_text("*1");
        frame.push_back(rbap_pkg::BYTE_LF);
        add_crlf();
        // sign, whitespace, empty count, zero count, wrong mark
        add_text("*-1");
        add_crlf();
        add_text("* 1");
        add_crlf();
        add_text("*");
        add_crlf();
        add_text("*0");
        add_crlf();
        add_text("$1");
        add_crlf();
        // string header faults after a good array header
        add_header(rbap_pkg::MARK_ARRAY, 64'd1);
        add_text("*3");
        add_crlf();
        add_header(rbap_pkg::MARK_ARRAY, 64'd1);
        add_text("$0");
        add_crlf();
        add_header(rbap_pkg::MARK_ARRAY, 64'd1);
        add_text("$2");
        frame.push_back(rbap_pkg::BYTE_CR);
        frame.push_back(rbap_pkg::BYTE_CR);
        send_frame();
    endtask

    task automatic test_count_extremes();
        // largest legal count, one string, then count limit plus one
        add_header(rbap_pkg::MARK_ARRAY, COUNT_MAX);
        add_header(rbap_pkg::MARK_STRING, 64'd1);
        add_text("Z");
        add_crlf();
        add_text("$9223372036854775808");
        add_crlf();
        add_text("*9223372036854775808");
        add_crlf();
        // leading zeros are plain digits
        add_text("*0000000000000000000000001");
        add_crlf();
        add_header(rbap_pkg::MARK_STRING, 64'd1);
        add_text("z");
        add_crlf();
        send_frame();
    endtask

    task automatic test_payload_faults();
        // payload runs past its length
        add_header(rbap_pkg::MARK_ARRAY, 64'd1);
        add_header(rbap_pkg::MARK_STRING, 64'd1);
        add_text("AB");
        // CR after payload, then something other than LF
        add_header(rbap_pkg::MARK_ARRAY, 64'd1);
        add_header(rbap_pkg::MARK_STRING, 64'd1);
        add_text("A");
        frame.push_back(rbap_pkg::BYTE_CR);
        add_text("Q");
        send_frame();
    endtask

    // receiver holds off while the sender streams payload, so the block fills
    // and raises its input stall
    task automatic test_backpressure();
        feed_idle  = 1'b0;
        drain_idle = 1'b0;
        hold_go    = 1'b1;
        add_header(rbap_pkg::MARK_ARRAY, 64'd2);
        add_header(rbap_pkg::MARK_STRING, 64'd40);
        repeat (40) frame.push_back(8'($urandom_range(0, 255)));
        add_crlf();
        add_header(rbap_pkg::MARK_STRING, 64'd3);
        add_text("end");
        add_crlf();
        send_frame();
        hold_go = 1'b0;
    endtask

    // mostly good messages, some damaged, odd counts and line noise
    task automatic test_random_traffic();
        int frames;
        int pick;
        int cut;
        frames = 0;
        while (bytes_sent < ITEM_TARGET) begin
            // idling changes in stretches, both off now and then
            if (frames % 25 == 0) begin
                feed_idle  = 1'($urandom_range(0, 1));
                drain_idle = 1'($urandom_range(0, 1));
            end
            pick = int'($urandom_range(0, 19));
            if (pick < 12) begin
                add_message(int'($urandom_range(1, 4)), ($urandom_range(0, 9) == 0) ? 40 : 6);
            end else if (pick < 16) begin
                add_message(int'($urandom_range(1, 3)), 6);
                if ($urandom_range(0, 1))
                    frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom_range(0, 255));
                else begin
                    cut = int'($urandom_range(1, frame.size() - 1));
                    while (frame.size() > cut)
                        frame.delete(frame.size() - 1);
                end
            end else if (pick < 18) begin
                // long digit run, may pass the count limit or come out zero
                frame.push_back(rbap_pkg::MARK_ARRAY);
                repeat ($urandom_range(1, 21))
                    frame.push_back(rbap_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
                add_crlf();
                add_header(rbap_pkg::MARK_STRING, 64'd2);
                add_text("ok");
                add_crlf();
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    case ($urandom_range(0, 2))
                        0: frame.push_back(rbap_pkg::BYTE_CR);
                        1: frame.push_back(rbap_pkg::BYTE_LF);
                        default: frame.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            send_frame();
            frames++;
        end
    endtask

    initial begin : main_flow
        int drain_cycles;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_in_byte = 8'h00;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_well_formed();
        test_header_faults();
        test_count_extremes();
        test_payload_faults();
        test_backpressure();
        test_random_traffic();

        // let the last events come out, then a few quiet cycles
        drain_cycles = 0;
        while (expected_events.size() > 0 && drain_cycles < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (8) @(negedge i_clk);
        if (expected_events.size() > 0)
            $display("%0d expected events never arrived", expected_events.size());

        $display("sent %0d stream bytes, checked %0d events, %0d mismatches",
                 bytes_sent, events_seen, mismatch_count);
        $display("covered header and payload faults, count limits and a %0d-cycle hold",
                 HOLD_CYCLES);
        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
